>>> hw/rtl/ssort_pkg.sv
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared constants and types for the stable sort block.
// ----------------------------------------------------------------------------
package ssort_pkg;

    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_VALUE_BITS = 31;
    localparam int DIGIT_BITS     = 4;
    localparam int RADIX          = 1 << DIGIT_BITS;

    typedef logic [DIGIT_BITS-1:0] digit_t;

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_PREFIX = 2'd1;
    localparam logic [1:0] ST_PLACE  = 2'd2;
    localparam logic [1:0] ST_OUTPUT = 2'd3;

endpackage

>>> hw/rtl/ssort_ram.sv
// ----------------------------------------------------------------------------
// ssort_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module ssort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/stable_sort_with_source_index.sv
// ----------------------------------------------------------------------------
// stable_sort_with_source_index
// Loads a set of values, sorts it stably in ascending order and emits each
// value with the load position of the first loaded item of equal value.
//
// Values are loaded one per cycle until the transaction marked last, or until
// MAX_ITEMS values are held. The set is then sorted by least-significant-digit
// counting passes of 4 bits each, ceil(VALUE_BITS/4) passes, ping-ponging
// between two RAMs of MAX_ITEMS words. Each pass first turns the digit
// histogram into start offsets, one digit at a time, then moves the n
// words, one word per cycle through the RAM read port; the histogram for
// the next digit is built while words move, and the first histogram while
// loading. Results then stream out at one per cycle while the receiver is
// ready. No input is taken from the end of loading until the last result
// of the set is accepted. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stable_sort_with_source_index
    import ssort_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [VALUE_BITS-1:0]        s_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [VALUE_BITS-1:0]        m_sorted_value,
    output logic [$clog2(MAX_ITEMS)-1:0] m_first_index,
    output logic                         m_end_of_run
);

    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int NUM_PASSES = (VALUE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_W      = NUM_PASSES * DIGIT_BITS;
    localparam int PASS_W     = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
    localparam int WORD_W     = VALUE_BITS + IDX_W;

    localparam logic              FINAL_SEL = 1'(NUM_PASSES % 2);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NUM_PASSES - 1);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ITEMS);

    function automatic digit_t digit_of(input logic [VALUE_BITS-1:0] v,
                                        input logic [PASS_W-1:0] p);
        logic [PAD_W-1:0] padded;
        digit_t           d;
        padded = PAD_W'(v);
        d      = '0;
        for (int k = 0; k < NUM_PASSES; k++) begin
            if (p == PASS_W'(k)) begin
                d = padded[k*DIGIT_BITS +: DIGIT_BITS];
            end
        end
        return d;
    endfunction

    logic [1:0]            state_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      run_reg;
    logic [PASS_W-1:0]     pass_reg;
    digit_t                k_reg;
    logic [CNT_W-1:0]      hist_reg [RADIX];
    logic [CNT_W-1:0]      offs_reg [RADIX];
    logic                  rd_vld_reg;
    logic                  rd_last_reg;
    logic                  first_pend_reg;
    logic                  m_valid_reg;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [IDX_W-1:0]      m_index_reg;
    logic                  m_end_reg;

    logic                  load_acc;
    logic                  src_sel;
    logic                  out_adv;
    logic                  issue_more;
    logic [CNT_W-1:0]      n_inc;
    logic [CNT_W-1:0]      n_last;
    logic [WORD_W-1:0]     rdata;
    logic [VALUE_BITS-1:0] rd_value;
    logic [IDX_W-1:0]      rd_index;
    digit_t                load_dig;
    digit_t                place_dig;
    digit_t                next_dig;
    logic [IDX_W-1:0]      place_pos;
    logic                  place_we;
    logic [IDX_W-1:0]      out_first;

    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic                  ram0_we;
    logic [IDX_W-1:0]      ram0_waddr;
    logic [WORD_W-1:0]     ram0_wdata;
    logic [WORD_W-1:0]     ram0_rdata;
    logic                  ram1_we;
    logic [WORD_W-1:0]     ram1_rdata;

    assign s_ready    = (state_reg == ST_LOAD);
    assign load_acc   = s_valid && s_ready;
    assign src_sel    = (state_reg == ST_OUTPUT) ? FINAL_SEL : pass_reg[0];
    assign rdata      = src_sel ? ram1_rdata : ram0_rdata;
    assign rd_value   = rdata[VALUE_BITS-1:0];
    assign rd_index   = rdata[WORD_W-1:VALUE_BITS];
    assign out_adv    = !m_valid_reg || m_ready;
    assign issue_more = (rd_ptr_reg != n_reg);
    assign n_inc      = n_reg + CNT_ONE;
    assign n_last     = n_reg - CNT_ONE;

    assign load_dig  = digit_of(s_value, '0);
    assign place_dig = digit_of(rd_value, pass_reg);
    assign next_dig  = digit_of(rd_value, pass_reg + PASS_W'(1));
    assign place_pos = offs_reg[place_dig][IDX_W-1:0];
    assign place_we  = (state_reg == ST_PLACE) && rd_vld_reg;
    assign out_first = (first_pend_reg || (rd_value != m_value_reg)) ? rd_index : m_index_reg;

    assign ram_re     = ((state_reg == ST_PLACE) && issue_more)
                     || ((state_reg == ST_OUTPUT) && issue_more && out_adv);
    assign ram_raddr  = rd_ptr_reg[IDX_W-1:0];
    assign ram0_we    = load_acc || (place_we && pass_reg[0]);
    assign ram0_waddr = load_acc ? n_reg[IDX_W-1:0] : place_pos;
    assign ram0_wdata = load_acc ? {n_reg[IDX_W-1:0], s_value} : rdata;
    assign ram1_we    = place_we && !pass_reg[0];

    ssort_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram0 (
        .aclk  (aclk),
        .we    (ram0_we),
        .waddr (ram0_waddr),
        .wdata (ram0_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram0_rdata)
    );

    ssort_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram1 (
        .aclk  (aclk),
        .we    (ram1_we),
        .waddr (place_pos),
        .wdata (rdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram1_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            n_reg          <= '0;
            rd_ptr_reg     <= '0;
            run_reg        <= '0;
            pass_reg       <= '0;
            k_reg          <= '0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            first_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < RADIX; i++) begin
                hist_reg[i] <= '0;
                offs_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (load_acc) begin
                        n_reg              <= n_inc;
                        hist_reg[load_dig] <= hist_reg[load_dig] + CNT_ONE;
                        if (s_last || (n_inc == CNT_MAX)) begin
                            state_reg <= ST_PREFIX;
                            k_reg     <= '0;
                            run_reg   <= '0;
                        end
                    end
                end
                ST_PREFIX: begin
                    offs_reg[k_reg] <= run_reg;
                    run_reg         <= run_reg + hist_reg[k_reg];
                    hist_reg[k_reg] <= '0;
                    k_reg           <= k_reg + digit_t'(1);
                    if (k_reg == digit_t'(RADIX - 1)) begin
                        state_reg  <= ST_PLACE;
                        rd_ptr_reg <= '0;
                    end
                end
                ST_PLACE: begin
                    if (issue_more) begin
                        rd_ptr_reg <= rd_ptr_reg + CNT_ONE;
                    end
                    rd_vld_reg  <= issue_more;
                    rd_last_reg <= issue_more && (rd_ptr_reg == n_last);
                    if (rd_vld_reg) begin
                        offs_reg[place_dig] <= offs_reg[place_dig] + CNT_ONE;
                        if (pass_reg != LAST_PASS) begin
                            hist_reg[next_dig] <= hist_reg[next_dig] + CNT_ONE;
                        end
                        if (rd_last_reg) begin
                            rd_ptr_reg <= '0;
                            if (pass_reg == LAST_PASS) begin
                                state_reg      <= ST_OUTPUT;
                                first_pend_reg <= 1'b1;
                            end else begin
                                pass_reg  <= pass_reg + PASS_W'(1);
                                state_reg <= ST_PREFIX;
                                k_reg     <= '0;
                                run_reg   <= '0;
                            end
                        end
                    end
                end
                ST_OUTPUT: begin
                    if (out_adv) begin
                        if (issue_more) begin
                            rd_ptr_reg <= rd_ptr_reg + CNT_ONE;
                        end
                        rd_vld_reg  <= issue_more;
                        rd_last_reg <= issue_more && (rd_ptr_reg == n_last);
                        m_valid_reg <= rd_vld_reg;
                        if (rd_vld_reg) begin
                            first_pend_reg <= 1'b0;
                        end
                    end
                    if (m_valid_reg && m_ready && m_end_reg) begin
                        state_reg  <= ST_LOAD;
                        n_reg      <= '0;
                        pass_reg   <= '0;
                        rd_ptr_reg <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUTPUT) && out_adv && rd_vld_reg) begin
            m_value_reg <= rd_value;
            m_index_reg <= out_first;
            m_end_reg   <= rd_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_first_index  = m_index_reg;
    assign m_end_of_run   = m_end_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("loading and result output overlap");

    a_offset_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        place_we |-> (offs_reg[place_dig] < n_reg))
        else $error("placement offset beyond set size");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_run) |=> (s_ready && !m_valid))
        else $error("block did not return to loading after last result");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> ((n_reg != '0) && (n_reg <= CNT_MAX)))
        else $error("set size out of range while sorting");

endmodule

>>> sim/stable_sort_with_source_index_tb.sv
// ----------------------------------------------------------------------------
// stable_sort_with_source_index_tb
// Sends sets of values to the stable sort block and checks every sorted
// result, with its first-occurrence index and end marker, against a
// scoreboard. The scoreboard sorts each closed set by stable insertion.
// Covers directed edge values, equal values, random sets under sender and
// receiver idling, and a long receiver hold-off across a store-full set.
// ----------------------------------------------------------------------------
module stable_sort_with_source_index_tb;
    import ssort_pkg::*;

    localparam int MAX_ITEMS   = DEF_MAX_ITEMS;
    localparam int VALUE_BITS  = DEF_VALUE_BITS;
    localparam int INDEX_BITS  = $clog2(MAX_ITEMS);
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [INDEX_BITS-1:0] index;
        logic                  end_of_run;
    } sort_result_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_BITS-1:0] s_value = '0;
    logic                  s_last  = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [VALUE_BITS-1:0] m_sorted_value;
    logic [INDEX_BITS-1:0] m_first_index;
    logic                  m_end_of_run;

    logic [VALUE_BITS-1:0] loaded_values[$];
    sort_result_t          sorted_results[$];
    sort_result_t          oldest_result;
    int                    error_count       = 0;
    int                    cycle_count       = 0;
    int                    sender_idle_pct   = 0;
    int                    receiver_idle_pct = 0;
    int                    hold_left         = 0;

    stable_sort_with_source_index #(
        .MAX_ITEMS (MAX_ITEMS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_first_index (m_first_index),
        .m_end_of_run  (m_end_of_run)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   = 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready = ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sorted_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d index=%0d end=%0b", $time,
                         m_sorted_value, m_first_index, m_end_of_run);
                error_count = error_count + 1;
            end else begin
                oldest_result = sorted_results.pop_front();
                if (m_sorted_value !== oldest_result.value) begin
                    $display("%0t: sorted_value expected %0d actual %0d", $time,
                             oldest_result.value, m_sorted_value);
                    error_count = error_count + 1;
                end
                if (m_first_index !== oldest_result.index) begin
                    $display("%0t: first_index expected %0d actual %0d", $time,
                             oldest_result.index, m_first_index);
                    error_count = error_count + 1;
                end
                if (m_end_of_run !== oldest_result.end_of_run) begin
                    $display("%0t: end_of_run expected %0b actual %0b", $time,
                             oldest_result.end_of_run, m_end_of_run);
                    error_count = error_count + 1;
                end
            end
        end
    end

    function automatic void sort_loaded_set();
        logic [VALUE_BITS-1:0] vals[MAX_ITEMS];
        int unsigned           pos[MAX_ITEMS];
        logic [VALUE_BITS-1:0] v;
        int unsigned           p;
        int unsigned           first;
        int                    n;
        int                    i;
        int                    j;
        sort_result_t          r;
        n     = loaded_values.size();
        first = 0;
        for (i = 0; i < n; i++) begin
            vals[i] = loaded_values[i];
            pos[i]  = i;
        end
        for (i = 1; i < n; i++) begin
            v = vals[i];
            p = pos[i];
            j = i - 1;
            while (j >= 0 && vals[j] > v) begin
                vals[j+1] = vals[j];
                pos[j+1]  = pos[j];
                j = j - 1;
            end
            vals[j+1] = v;
            pos[j+1]  = p;
        end
        for (i = 0; i < n; i++) begin
            if (i == 0 || vals[i] != vals[i-1]) begin
                first = pos[i];
            end
            r.value      = vals[i];
            r.index      = first[INDEX_BITS-1:0];
            r.end_of_run = (i == n - 1);
            sorted_results.push_back(r);
        end
        loaded_values.delete();
    endfunction

    function automatic void load_value(input logic [VALUE_BITS-1:0] value, input logic last);
        loaded_values.push_back(value);
        if (last || loaded_values.size() == MAX_ITEMS) begin
            sort_loaded_set();
        end
    endfunction

    task automatic send_item(input logic [VALUE_BITS-1:0] value, input logic last);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_value = value;
        s_last  = last;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        load_value(value, last);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sorted_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(4))
            0: return raw[VALUE_BITS-1:0];
            1: return VALUE_BITS'($urandom_range(15));
            2: return VALUE_BITS'(raw >> $urandom_range(31));
            3: begin
                if (loaded_values.size() > 0) begin
                    return loaded_values[$urandom_range(loaded_values.size() - 1)];
                end
                return raw[VALUE_BITS-1:0];
            end
            default: return {raw[VALUE_BITS-1:VALUE_BITS-4], {(VALUE_BITS-4){1'b0}}};
        endcase
    endfunction

    task automatic test_extreme_values();
        send_item(VALUE_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item(31'h2AAA_AAAA, 1'b0);
        send_item(31'h5555_5555, 1'b0);
        send_item(31'd1, 1'b1);
        send_item(VALUE_MAX, 1'b1);
        send_item('0, 1'b1);
        wait_drained();
    endtask

    task automatic test_equal_values();
        send_item(31'd7, 1'b0);
        send_item(31'd3, 1'b0);
        send_item(31'h1000_0005, 1'b0);
        send_item(31'd7, 1'b0);
        send_item(31'd5, 1'b0);
        send_item(31'd3, 1'b0);
        send_item(31'h1000_0005, 1'b0);
        send_item(31'd5, 1'b0);
        send_item(31'd7, 1'b1);
        repeat (4) send_item(31'h4000_0000, 1'b0);
        send_item(31'h4000_0000, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_sets(input int item_count);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < item_count) begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
                send_item(pick_value(), k == len - 1);
            end
            sent = sent + len;
        end
        wait_drained();
    endtask

    task automatic test_back_pressure();
        int k;
        hold_left = 1000;
        for (k = 0; k < MAX_ITEMS; k++) begin
            send_item(pick_value(), 1'b0);
        end
        for (k = 0; k < 6; k++) begin
            send_item(pick_value(), k == 5);
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        sender_idle_pct   = 19;
        receiver_idle_pct = 53;
        test_extreme_values();
        test_equal_values();
        test_random_sets(20);

        sender_idle_pct   = 53;
        receiver_idle_pct = 19;
        test_random_sets(20);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_sets(20);
        test_back_pressure();

        repeat (40) @(posedge aclk);
        if (error_count == 0 && sorted_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
